@@ hdl/assert_macros.svh @@
// Assertion macros shared by the rational matrix reducer RTL.
// Needs nothing else; include it in the module that asserts.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define RMR_ASSERT_IMP(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");

// Next-cycle implication, disabled while reset is low.
`define RMR_ASSERT_NXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`endif

@@ hdl/rmr_pkg.sv @@
// Types and codes shared by the rational matrix reducer.
// No dependencies.
package rmr_pkg;

  typedef struct packed {
    logic [63:0] num;
    logic [63:0] den;
  } rat_t;

  localparam logic [1:0] OP_MK  = 2'd0;
  localparam logic [1:0] OP_MUL = 2'd1;
  localparam logic [1:0] OP_DIV = 2'd2;
  localparam logic [1:0] OP_SUB = 2'd3;

  typedef struct packed {
    logic       start;
    logic [1:0] op;
  } ratu_req_t;

  // Row and column counters must hold up to 16.
  localparam int CNT_W = 5;

endpackage

@@ hdl/rmr_intf.sv @@
// Handshake channel interfaces for the rational matrix reducer.
// Needs no package; widths are those of the item fields.
interface rmr_in_if;
  logic               valid;
  logic               ready;
  logic               func;
  logic [1:0]         row;
  logic [2:0]         col;
  logic signed [63:0] entry_num;
  logic signed [63:0] entry_den;

  modport source (output valid, func, row, col, entry_num, entry_den, input ready);
  modport sink (input valid, func, row, col, entry_num, entry_den, output ready);
endinterface

interface rmr_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         out_row;
  logic [2:0]         out_col;
  logic signed [63:0] result_num;
  logic signed [63:0] result_den;
  logic [2:0]         pivot_col_of_row;
  logic               row_has_pivot;
  logic               last;

  modport source (output valid, out_row, out_col, result_num, result_den,
                  pivot_col_of_row, row_has_pivot, last, input ready);
  modport sink (input valid, out_row, out_col, result_num, result_den,
                pivot_col_of_row, row_has_pivot, last, output ready);
endinterface

@@ hdl/rational_matrix_rref_top.sv @@
// Top level of the rational matrix reducer: sequencer, matrix memories, ports.
// Depends on rmr_pkg, rmr_intf.sv, rmr_ratu and assert_macros.svh.
//
// A load item (func 0) normalizes one entry and stores it; it occupies the block
// through the Euclid steps of the gcd and, when the gcd exceeds one, two scaling
// divides. A run item (func 1) copies the whole stored matrix, reduces the copy,
// then emits one result item per active entry, each after a read state and held
// through any output stall. Every rational operation of the reduction goes
// through the single shared unit: 32x32 multiplies, then the gcd and scaling
// divides on its one-bit-per-cycle divider, which sets the run time. The input
// is not ready until the item's last result has been taken.
`include "assert_macros.svh"

module rational_matrix_rref_top #(
  parameter int MAX_ROWS = 4,
  parameter int MAX_COLS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  rmr_in_if.sink      in_ch,
  rmr_out_if.source   out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import rmr_pkg::*;

  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int RIW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam logic [CNT_W-1:0] ONE = CNT_W'(1);

  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_LD_WAIT = 5'd1;
  localparam logic [4:0] S_CP_RD   = 5'd2;
  localparam logic [4:0] S_CP_WR   = 5'd3;
  localparam logic [4:0] S_COL     = 5'd4;
  localparam logic [4:0] S_PS_RD   = 5'd5;
  localparam logic [4:0] S_PS_CHK  = 5'd6;
  localparam logic [4:0] S_SW_A    = 5'd7;
  localparam logic [4:0] S_SW_B    = 5'd8;
  localparam logic [4:0] S_SW_C    = 5'd9;
  localparam logic [4:0] S_SW_D    = 5'd10;
  localparam logic [4:0] S_PV_RD   = 5'd11;
  localparam logic [4:0] S_PV_LAT  = 5'd12;
  localparam logic [4:0] S_SC_RD   = 5'd13;
  localparam logic [4:0] S_SC_GO   = 5'd14;
  localparam logic [4:0] S_SC_WAIT = 5'd15;
  localparam logic [4:0] S_EL_RD   = 5'd16;
  localparam logic [4:0] S_EL_CHK  = 5'd17;
  localparam logic [4:0] S_EL_RK   = 5'd18;
  localparam logic [4:0] S_EL_MUL  = 5'd19;
  localparam logic [4:0] S_EL_MW   = 5'd20;
  localparam logic [4:0] S_EL_RI   = 5'd21;
  localparam logic [4:0] S_EL_SUB  = 5'd22;
  localparam logic [4:0] S_EL_SW   = 5'd23;
  localparam logic [4:0] S_PIV     = 5'd24;
  localparam logic [4:0] S_EM_RD   = 5'd25;
  localparam logic [4:0] S_EM_OUT  = 5'd26;

  localparam logic REG_ROWS = 1'b0;
  localparam logic REG_COLS = 1'b1;

  function automatic logic [AW-1:0] addr_of(input logic [CNT_W-1:0] r,
                                            input logic [CNT_W-1:0] c);
    logic [15:0] s;
    s = 16'(r) * 16'(MAX_COLS) + 16'(c);
    return s[AW-1:0];
  endfunction

  function automatic logic is_zero(input rat_t a);
    return (a.num == 64'd0) && (a.den == 64'd1);
  endfunction

  logic [4:0]       st_r;
  logic [2:0]       cfg_rows_r;
  logic [3:0]       cfg_cols_r;
  logic [CNT_W-1:0] rows_r, cols_r, rr_r, cc_r, pp_r, ii_r, kk_r, rank_r;
  logic [CNT_W-1:0] rows_cl, cols_cl, rd_row, rd_col;
  logic [AW:0]      cp_r;
  logic [2:0]       piv_r [MAX_ROWS];
  logic [AW-1:0]    ld_addr_r, wk_ra, wk_wa;
  rat_t             store_mem [DEPTH];
  rat_t             work_mem [DEPTH];
  rat_t             st_rd_r, wk_rd_r, tmp_r, pv_r, f_r, t_r, wk_wd, u_a, u_b, u_res;
  logic             wk_we, u_done, in_fire, ld_ok, cfg_wr, k_last, has_piv;
  ratu_req_t        u_req;

  assign in_fire = in_ch.valid && in_ch.ready;
  assign ld_ok   = (CNT_W'(in_ch.row) < CNT_W'(MAX_ROWS)) &&
                   (CNT_W'(in_ch.col) < CNT_W'(MAX_COLS));
  assign k_last  = (kk_r == cols_r - ONE);

  // Register values outside the legal range saturate at run start.
  always_comb begin
    if (cfg_rows_r == 3'd0) rows_cl = ONE;
    else if (CNT_W'(cfg_rows_r) > CNT_W'(MAX_ROWS)) rows_cl = CNT_W'(MAX_ROWS);
    else rows_cl = CNT_W'(cfg_rows_r);
    if (cfg_cols_r == 4'd0) cols_cl = ONE;
    else if (CNT_W'(cfg_cols_r) > CNT_W'(MAX_COLS)) cols_cl = CNT_W'(MAX_COLS);
    else cols_cl = CNT_W'(cfg_cols_r);
  end

  // Configuration port.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == REG_COLS) ? {28'd0, cfg_cols_r} : {29'd0, cfg_rows_r};

  // Read address of the working copy; the read data is registered and arrives in the next cycle.
  always_comb begin
    case (st_r)
      S_PS_RD:                    begin rd_row = pp_r; rd_col = cc_r; end
      S_SW_A, S_SC_RD, S_EL_RK:   begin rd_row = rr_r; rd_col = kk_r; end
      S_SW_B:                     begin rd_row = pp_r; rd_col = kk_r; end
      S_PV_RD:                    begin rd_row = rr_r; rd_col = cc_r; end
      S_EL_RD:                    begin rd_row = ii_r; rd_col = cc_r; end
      S_EL_RI, S_EM_RD, S_EM_OUT: begin rd_row = ii_r; rd_col = kk_r; end
      default:                    begin rd_row = rr_r; rd_col = kk_r; end
    endcase
    wk_ra = addr_of(rd_row, rd_col);
  end

  // Requests to the shared unit and writes to the working copy.
  always_comb begin
    u_req.start = 1'b0;
    u_req.op    = OP_MK;
    u_a         = wk_rd_r;
    u_b         = wk_rd_r;
    wk_we       = 1'b0;
    wk_wa       = addr_of(rr_r, kk_r);
    wk_wd       = u_res;
    case (st_r)
      S_IDLE: begin
        u_req.start = in_fire && !in_ch.func && ld_ok;
        u_a.num     = in_ch.entry_num;
        u_a.den     = in_ch.entry_den;
      end
      S_CP_WR: begin
        wk_we = 1'b1;
        wk_wa = cp_r[AW-1:0];
        wk_wd = st_rd_r;
      end
      S_SW_C: begin
        wk_we = 1'b1;
        wk_wd = wk_rd_r;
      end
      S_SW_D: begin
        wk_we = 1'b1;
        wk_wa = addr_of(pp_r, kk_r);
        wk_wd = tmp_r;
      end
      S_SC_GO: begin
        u_req.start = 1'b1;
        u_req.op    = OP_DIV;
        u_b         = pv_r;
      end
      S_SC_WAIT: wk_we = u_done;
      S_EL_MUL: begin
        u_req.start = 1'b1;
        u_req.op    = OP_MUL;
        u_a         = f_r;
      end
      S_EL_SUB: begin
        u_req.start = 1'b1;
        u_req.op    = OP_SUB;
        u_b         = t_r;
      end
      S_EL_SW: begin
        wk_we = u_done;
        wk_wa = addr_of(ii_r, kk_r);
      end
      default: begin
      end
    endcase
  end

  rmr_ratu u_ratu (
    .clk    (clk),
    .rst_n  (rst_n),
    .req_i  (u_req),
    .a_i    (u_a),
    .b_i    (u_b),
    .done_o (u_done),
    .res_o  (u_res)
  );

  always_ff @(posedge clk) begin
    if (st_r == S_LD_WAIT && u_done) store_mem[ld_addr_r] <= u_res;
    st_rd_r <= store_mem[cp_r[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (wk_we) work_mem[wk_wa] <= wk_wd;
    wk_rd_r <= work_mem[wk_ra];
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (st_r == S_IDLE && in_fire) ld_addr_r <= addr_of(CNT_W'(in_ch.row), CNT_W'(in_ch.col));
    if (st_r == S_SW_B) tmp_r <= wk_rd_r;
    if (st_r == S_PV_LAT) pv_r <= wk_rd_r;
    if (st_r == S_EL_CHK) f_r <= wk_rd_r;
    if (st_r == S_EL_MW && u_done) t_r <= u_res;
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= S_IDLE;
      cfg_rows_r <= 3'd4;
      cfg_cols_r <= 4'd8;
      rows_r     <= ONE;
      cols_r     <= ONE;
      rr_r       <= '0;
      cc_r       <= '0;
      pp_r       <= '0;
      ii_r       <= '0;
      kk_r       <= '0;
      cp_r       <= '0;
      rank_r     <= '0;
      for (int j = 0; j < MAX_ROWS; j++) piv_r[j] <= 3'd0;
    end else begin
      if (cfg_wr) begin
        if (paddr[2] == REG_ROWS) cfg_rows_r <= pwdata[2:0];
        else cfg_cols_r <= pwdata[3:0];
      end
      case (st_r)
        S_IDLE: begin
          if (in_fire) begin
            if (in_ch.func) begin
              rows_r <= rows_cl;
              cols_r <= cols_cl;
              cp_r   <= '0;
              st_r   <= S_CP_RD;
            end else if (ld_ok) begin
              st_r <= S_LD_WAIT;
            end
          end
        end
        S_LD_WAIT: if (u_done) st_r <= S_IDLE;
        S_CP_RD: st_r <= S_CP_WR;
        S_CP_WR: begin
          if (cp_r == (AW+1)'(DEPTH - 1)) begin
            rr_r <= '0;
            cc_r <= '0;
            st_r <= S_COL;
          end else begin
            cp_r <= cp_r + (AW+1)'(1);
            st_r <= S_CP_RD;
          end
        end
        S_COL: begin
          if (cc_r >= cols_r || rr_r >= rows_r) begin
            rank_r <= rr_r;
            ii_r   <= '0;
            kk_r   <= '0;
            st_r   <= S_EM_RD;
          end else begin
            pp_r <= rr_r;
            st_r <= S_PS_RD;
          end
        end
        S_PS_RD: begin
          if (pp_r == rows_r) begin
            cc_r <= cc_r + ONE;
            st_r <= S_COL;
          end else begin
            st_r <= S_PS_CHK;
          end
        end
        S_PS_CHK: begin
          if (is_zero(wk_rd_r)) begin
            pp_r <= pp_r + ONE;
            st_r <= S_PS_RD;
          end else if (pp_r == rr_r) begin
            st_r <= S_PV_RD;
          end else begin
            kk_r <= '0;
            st_r <= S_SW_A;
          end
        end
        S_SW_A: st_r <= S_SW_B;
        S_SW_B: st_r <= S_SW_C;
        S_SW_C: st_r <= S_SW_D;
        S_SW_D: begin
          if (k_last) begin
            st_r <= S_PV_RD;
          end else begin
            kk_r <= kk_r + ONE;
            st_r <= S_SW_A;
          end
        end
        S_PV_RD: st_r <= S_PV_LAT;
        S_PV_LAT: begin
          kk_r <= cc_r;
          st_r <= S_SC_RD;
        end
        S_SC_RD: st_r <= S_SC_GO;
        S_SC_GO: st_r <= S_SC_WAIT;
        S_SC_WAIT: begin
          if (u_done) begin
            if (k_last) begin
              ii_r <= '0;
              st_r <= S_EL_RD;
            end else begin
              kk_r <= kk_r + ONE;
              st_r <= S_SC_RD;
            end
          end
        end
        S_EL_RD: begin
          if (ii_r == rows_r) begin
            st_r <= S_PIV;
          end else if (ii_r == rr_r) begin
            ii_r <= ii_r + ONE;
          end else begin
            st_r <= S_EL_CHK;
          end
        end
        S_EL_CHK: begin
          if (is_zero(wk_rd_r)) begin
            ii_r <= ii_r + ONE;
            st_r <= S_EL_RD;
          end else begin
            kk_r <= cc_r;
            st_r <= S_EL_RK;
          end
        end
        S_EL_RK: st_r <= S_EL_MUL;
        S_EL_MUL: st_r <= S_EL_MW;
        S_EL_MW: if (u_done) st_r <= S_EL_RI;
        S_EL_RI: st_r <= S_EL_SUB;
        S_EL_SUB: st_r <= S_EL_SW;
        S_EL_SW: begin
          if (u_done) begin
            if (k_last) begin
              ii_r <= ii_r + ONE;
              st_r <= S_EL_RD;
            end else begin
              kk_r <= kk_r + ONE;
              st_r <= S_EL_RK;
            end
          end
        end
        S_PIV: begin
          piv_r[rr_r[RIW-1:0]] <= cc_r[2:0];
          rr_r <= rr_r + ONE;
          cc_r <= cc_r + ONE;
          st_r <= S_COL;
        end
        S_EM_RD: st_r <= S_EM_OUT;
        S_EM_OUT: begin
          if (out_ch.ready) begin
            if (k_last) begin
              if (ii_r == rows_r - ONE) begin
                st_r <= S_IDLE;
              end else begin
                ii_r <= ii_r + ONE;
                kk_r <= '0;
                st_r <= S_EM_RD;
              end
            end else begin
              kk_r <= kk_r + ONE;
              st_r <= S_EM_RD;
            end
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign in_ch.ready = (st_r == S_IDLE);

  assign has_piv                 = (ii_r < rank_r);
  assign out_ch.valid            = (st_r == S_EM_OUT);
  assign out_ch.out_row          = ii_r[1:0];
  assign out_ch.out_col          = kk_r[2:0];
  assign out_ch.result_num       = wk_rd_r.num;
  assign out_ch.result_den       = wk_rd_r.den;
  assign out_ch.pivot_col_of_row = has_piv ? piv_r[ii_r[RIW-1:0]] : 3'd0;
  assign out_ch.row_has_pivot    = has_piv;
  assign out_ch.last             = k_last && (ii_r == rows_r - ONE);

  `RMR_ASSERT_IMP(a_ready_no_out, clk, rst_n, in_ch.ready, !out_ch.valid)
  `RMR_ASSERT_NXT(a_last_to_idle, clk, rst_n,
                  out_ch.valid && out_ch.ready && out_ch.last, in_ch.ready)
  `RMR_ASSERT_NXT(a_load_done_idle, clk, rst_n, (st_r == S_LD_WAIT) && u_done, in_ch.ready)
  `RMR_ASSERT_IMP(a_rows_legal, clk, rst_n, st_r != S_IDLE,
                  (rows_r >= ONE) && (rows_r <= CNT_W'(MAX_ROWS)))

endmodule

@@ hdl/rmr_ratu.sv @@
// Shared rational arithmetic unit: one 32x32 multiplier and one radix-2 divider.
// Depends on rmr_pkg.
module rmr_ratu (
  input  logic               clk,
  input  logic               rst_n,
  input  rmr_pkg::ratu_req_t req_i,
  input  rmr_pkg::rat_t      a_i,
  input  rmr_pkg::rat_t      b_i,
  output logic               done_o,
  output rmr_pkg::rat_t      res_o
);
  import rmr_pkg::*;

  localparam logic [3:0] U_IDLE = 4'd0;
  localparam logic [3:0] U_MUL  = 4'd1;
  localparam logic [3:0] U_ZCHK = 4'd2;
  localparam logic [3:0] U_SIGN = 4'd3;
  localparam logic [3:0] U_GCD  = 4'd4;
  localparam logic [3:0] U_GDIV = 4'd5;
  localparam logic [3:0] U_SCN  = 4'd6;
  localparam logic [3:0] U_SDN  = 4'd7;
  localparam logic [3:0] U_SDD  = 4'd8;
  localparam logic [3:0] U_DONE = 4'd9;

  function automatic logic [63:0] mag64(input logic [63:0] x);
    return x[63] ? (64'd0 - x) : x;
  endfunction

  logic [3:0]  st_r, st_nxt;
  logic [1:0]  op_r, pi_r, ms_r, pi_last;
  logic [63:0] an_r, ad_r, bn_r, bd_r;
  logic [63:0] acc_r, n_r, d_r, ga_r, gb_r;
  logic [63:0] dq_r, drem_r, dvs_r;
  logic [5:0]  dcnt_r;
  logic [63:0] mx, my, prod, acc_sum, n_s, d_s, q_new;
  logic [31:0] ma, mb;
  logic [64:0] rem_sh, rem_new;
  logic        ge, div_last;

  // Operand pairs of the two or three 64-bit products of each multiply, divide or subtract.
  always_comb begin
    mx = an_r;
    my = bn_r;
    case (op_r)
      OP_MUL: begin
        if (pi_r == 2'd0) begin
          mx = an_r; my = bn_r;
        end else begin
          mx = ad_r; my = bd_r;
        end
      end
      OP_DIV: begin
        if (pi_r == 2'd0) begin
          mx = an_r; my = bd_r;
        end else begin
          mx = ad_r; my = bn_r;
        end
      end
      OP_SUB: begin
        case (pi_r)
          2'd0: begin mx = an_r; my = bd_r; end
          2'd1: begin mx = ad_r; my = bd_r; end
          default: begin mx = bn_r; my = ad_r; end
        endcase
      end
      default: begin
        mx = an_r; my = bn_r;
      end
    endcase
    pi_last = (op_r == OP_SUB) ? 2'd2 : 2'd1;
  end

  // A wrapped 64-bit product needs only three 32-bit partial products.
  always_comb begin
    case (ms_r)
      2'd0: begin ma = mx[31:0];  mb = my[31:0];  end
      2'd1: begin ma = mx[31:0];  mb = my[63:32]; end
      default: begin ma = mx[63:32]; mb = my[31:0]; end
    endcase
  end

  assign prod    = 64'(ma) * 64'(mb);
  assign acc_sum = acc_r + {prod[31:0], 32'd0};

  assign rem_sh   = {drem_r, dq_r[63]};
  assign ge       = rem_sh >= {1'b0, dvs_r};
  assign rem_new  = ge ? (rem_sh - {1'b0, dvs_r}) : rem_sh;
  assign q_new    = {dq_r[62:0], ge};
  assign div_last = (dcnt_r == 6'd63);

  assign n_s = d_r[63] ? (64'd0 - n_r) : n_r;
  assign d_s = d_r[63] ? (64'd0 - d_r) : d_r;

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      U_IDLE: if (req_i.start) st_nxt = (req_i.op == OP_MK) ? U_ZCHK : U_MUL;
      U_MUL:  if (ms_r == 2'd2 && pi_r == pi_last) st_nxt = U_ZCHK;
      U_ZCHK: st_nxt = (n_r == 64'd0 || d_r == 64'd0) ? U_DONE : U_SIGN;
      U_SIGN: st_nxt = U_GCD;
      U_GCD:  st_nxt = (gb_r == 64'd0) ? U_SCN : U_GDIV;
      U_GDIV: if (div_last) st_nxt = U_GCD;
      U_SCN:  st_nxt = (ga_r > 64'd1) ? U_SDN : U_DONE;
      U_SDN:  if (div_last) st_nxt = U_SDD;
      U_SDD:  if (div_last) st_nxt = U_DONE;
      U_DONE: st_nxt = U_IDLE;
      default: st_nxt = U_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= U_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (st_r)
      U_IDLE: begin
        if (req_i.start) begin
          op_r <= req_i.op;
          an_r <= a_i.num;
          ad_r <= a_i.den;
          bn_r <= b_i.num;
          bd_r <= b_i.den;
          pi_r <= 2'd0;
          ms_r <= 2'd0;
          n_r  <= a_i.num;
          d_r  <= a_i.den;
        end
      end
      U_MUL: begin
        case (ms_r)
          2'd0: begin
            acc_r <= prod;
            ms_r  <= 2'd1;
          end
          2'd1: begin
            acc_r <= acc_sum;
            ms_r  <= 2'd2;
          end
          default: begin
            ms_r <= 2'd0;
            pi_r <= pi_r + 2'd1;
            case (pi_r)
              2'd0: n_r <= acc_sum;
              2'd1: d_r <= acc_sum;
              default: n_r <= n_r - acc_sum;
            endcase
          end
        endcase
      end
      U_ZCHK: begin
        if (n_r == 64'd0 || d_r == 64'd0) begin
          n_r <= 64'd0;
          d_r <= 64'd1;
        end
      end
      U_SIGN: begin
        n_r  <= n_s;
        d_r  <= d_s;
        ga_r <= mag64(n_s);
        gb_r <= mag64(d_s);
      end
      U_GCD: begin
        if (gb_r != 64'd0) begin
          dq_r   <= ga_r;
          drem_r <= 64'd0;
          dvs_r  <= gb_r;
          dcnt_r <= 6'd0;
        end
      end
      U_GDIV: begin
        dq_r   <= q_new;
        drem_r <= rem_new[63:0];
        dcnt_r <= dcnt_r + 6'd1;
        if (div_last) begin
          ga_r <= gb_r;
          gb_r <= rem_new[63:0];
        end
      end
      U_SCN: begin
        if (ga_r > 64'd1) begin
          dq_r   <= mag64(n_r);
          drem_r <= 64'd0;
          dvs_r  <= ga_r;
          dcnt_r <= 6'd0;
        end
      end
      U_SDN: begin
        if (div_last) begin
          n_r    <= n_r[63] ? (64'd0 - q_new) : q_new;
          dq_r   <= mag64(d_r);
          drem_r <= 64'd0;
          dcnt_r <= 6'd0;
        end else begin
          dq_r   <= q_new;
          drem_r <= rem_new[63:0];
          dcnt_r <= dcnt_r + 6'd1;
        end
      end
      U_SDD: begin
        dq_r   <= q_new;
        drem_r <= rem_new[63:0];
        dcnt_r <= dcnt_r + 6'd1;
        if (div_last) d_r <= d_r[63] ? (64'd0 - q_new) : q_new;
      end
      default: begin
      end
    endcase
  end

  assign done_o    = (st_r == U_DONE);
  assign res_o.num = n_r;
  assign res_o.den = d_r;

endmodule
